FILE: sv/lrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrle_pkg
// Shared types and constants of the level run-length encoder.
// ----------------------------------------------------------------------------
package lrle_pkg;

    localparam int unsigned LEVEL_W        = 16;
    localparam int unsigned RUN_LEN_W      = 16;
    localparam int unsigned WIDTH_CFG_W    = 5;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned MAX_RUN_DEF    = 65535;
    localparam int unsigned CMD_FIFO_DEPTH = 4;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 5'd1;

    typedef struct packed {
        logic [LEVEL_W-1:0]   value;
        logic [RUN_LEN_W-1:0] length;
        logic                 last;
    } t_run_cmd;

endpackage

FILE: sv/lrle_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrle_intf
// Valid/ready channels: level requests in, encoded bytes out, width writes.
// ----------------------------------------------------------------------------
interface lrle_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] level;
    logic        end_of_stream;

    modport source (output valid, output level, output end_of_stream, input ready);
    modport sink   (input valid, input level, input end_of_stream, output ready);
endinterface

interface lrle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       final_byte;

    modport source (output valid, output out_byte, output final_byte, input ready);
    modport sink   (input valid, input out_byte, input final_byte, output ready);
endinterface

interface lrle_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] level_bit_width;

    modport source (output valid, output level_bit_width, input ready);
    modport sink   (input valid, input level_bit_width, output ready);
endinterface

FILE: sv/lrle_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrle_cmd_fifo
// Short queue of run commands between the run tracker and the byte emitter.
// ----------------------------------------------------------------------------
module lrle_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrle_pkg::t_run_cmd i_push_data,
    output logic              o_full,
    output logic              o_head_valid,
    output lrle_pkg::t_run_cmd o_head,
    input  logic              i_pop
);
    import lrle_pkg::*;

    localparam int unsigned PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    t_run_cmd         r_mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(CMD_FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full       = (r_count == CNT_W'(CMD_FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("run command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("run command queue underflow");

endmodule

FILE: sv/lrle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrle_front
// Run tracker: accept level requests, group equal levels, queue finished runs.
// ----------------------------------------------------------------------------
module lrle_front #(
    parameter int unsigned MAX_RUN = lrle_pkg::MAX_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrle_in_if.sink            i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output lrle_pkg::t_run_cmd o_push_data
);
    import lrle_pkg::*;

    logic [LEVEL_W-1:0]   r_value, n_value;
    logic [RUN_LEN_W-1:0] r_length, n_length;
    logic                 r_open, n_open;
    logic                 r_pend_valid, n_pend_valid;
    t_run_cmd             r_pend, n_pend;

    logic                 accept;
    logic                 extend;
    logic                 emit_prev;
    logic [LEVEL_W-1:0]   cur_value;
    logic [RUN_LEN_W-1:0] cur_length;
    t_run_cmd             prev_cmd;
    t_run_cmd             flush_cmd;

    assign i_in.ready = !r_pend_valid && !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        extend     = r_open && (i_in.level == r_value)
                     && (r_length < RUN_LEN_W'(MAX_RUN));
        emit_prev  = r_open && !extend;
        cur_value  = extend ? r_value : i_in.level;
        cur_length = extend ? (r_length + RUN_LEN_W'(1)) : RUN_LEN_W'(1);

        prev_cmd.value   = r_value;
        prev_cmd.length  = r_length;
        prev_cmd.last    = 1'b0;
        flush_cmd.value  = cur_value;
        flush_cmd.length = cur_length;
        flush_cmd.last   = 1'b1;

        n_value      = r_value;
        n_length     = r_length;
        n_open       = r_open;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_push       = 1'b0;
        o_push_data  = r_pend;

        if (r_pend_valid) begin
            if (!i_q_full) begin
                o_push       = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (accept) begin
            if (i_in.end_of_stream) begin
                n_value  = '0;
                n_length = '0;
                n_open   = 1'b0;
                o_push   = 1'b1;
                if (emit_prev) begin
                    o_push_data  = prev_cmd;
                    n_pend       = flush_cmd;
                    n_pend_valid = 1'b1;
                end else begin
                    o_push_data = flush_cmd;
                end
            end else begin
                n_value     = cur_value;
                n_length    = cur_length;
                n_open      = 1'b1;
                o_push      = emit_prev;
                o_push_data = prev_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value      <= '0;
            r_length     <= '0;
            r_open       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_value      <= n_value;
            r_length     <= n_length;
            r_open       <= n_open;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    a_eos_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.end_of_stream) |=> (!r_open && r_length == '0))
        else $error("run still open after end of stream");

    a_pend_is_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend.last && !r_open))
        else $error("held run command is not a stream flush");

endmodule

FILE: sv/lrle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrle_back
// Byte emitter: queued runs to varint header and value bytes (none at width 0).
// ----------------------------------------------------------------------------
module lrle_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrle_cfg_if.sink           i_cfg,
    input  logic               i_head_valid,
    input  lrle_pkg::t_run_cmd i_head,
    output logic               o_pop,
    lrle_out_if.source         o_out
);
    import lrle_pkg::*;

    logic [WIDTH_CFG_W-1:0] r_width;
    logic [2:0]             r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]      r_out_byte, n_out_byte;
    logic                   r_out_final, n_out_final;

    logic [RUN_LEN_W:0]     hdr;
    logic [2:0]             hdr_bytes;
    logic [2:0]             val_bytes;
    logic [2:0]             total;
    logic [2:0]             val_idx;
    logic                   is_last;
    logic                   slot_free;
    logic                   advance;

    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.final_byte = r_out_final;

    always_comb begin
        hdr = {i_head.length, 1'b0};
        if (hdr[RUN_LEN_W:14] != '0) begin
            hdr_bytes = 3'd3;
        end else if (hdr[13:7] != '0) begin
            hdr_bytes = 3'd2;
        end else begin
            hdr_bytes = 3'd1;
        end
        if (r_width == '0) begin
            val_bytes = 3'd0;
        end else if (r_width <= WIDTH_CFG_W'(8)) begin
            val_bytes = 3'd1;
        end else begin
            val_bytes = 3'd2;
        end
        total     = hdr_bytes + val_bytes;
        val_idx   = r_idx - hdr_bytes;
        is_last   = (r_idx == total - 3'd1);
        slot_free = !r_out_valid || o_out.ready;
        advance   = i_head_valid && (val_bytes != '0) && slot_free;
        o_pop     = i_head_valid && ((val_bytes == '0) || (slot_free && is_last));

        n_out_byte = r_out_byte;
        if (r_idx < hdr_bytes) begin
            case (r_idx)
                3'd0:    n_out_byte = {(hdr_bytes > 3'd1), hdr[6:0]};
                3'd1:    n_out_byte = {(hdr_bytes > 3'd2), hdr[13:7]};
                default: n_out_byte = {5'd0, hdr[RUN_LEN_W:14]};
            endcase
        end else begin
            n_out_byte = val_idx[0] ? i_head.value[15:8] : i_head.value[7:0];
        end
        n_out_final = i_head.last && is_last;

        n_out_valid = r_out_valid && !o_out.ready;
        n_idx       = r_idx;
        if (advance) begin
            n_out_valid = 1'b1;
            n_idx       = is_last ? 3'd0 : (r_idx + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_width <= i_cfg.level_bit_width;
            end
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte  <= n_out_byte;
            r_out_final <= n_out_final;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && val_bytes != '0) |-> (r_idx < total))
        else $error("byte index beyond run length");

    a_final_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out_final) |-> o_pop)
        else $error("final byte emitted before run command retired");

endmodule

FILE: sv/level_run_length_encoder_top.sv
`timescale 1ns / 1ps
// A run's first byte passes the command queue, then the output byte register.
// Throughput: one level request per cycle while runs grow and the queue has room;
// each finished run then leaves the byte emitter as header and value bytes.
// End of stream that also closes a run holds the input until the flush is queued.
// Reset: synchronous, active low; clears run state and queue, width returns to 1.
// ----------------------------------------------------------------------------
// level_run_length_encoder_top
// Run-length encoder for level streams: varint run header, then value bytes.
// ----------------------------------------------------------------------------
module level_run_length_encoder_top #(
    parameter int unsigned MAX_RUN = lrle_pkg::MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrle_cfg_if.sink   i_cfg,
    lrle_in_if.sink    i_in,
    lrle_out_if.source o_out
);
    import lrle_pkg::*;

    logic     q_push;
    t_run_cmd q_push_data;
    logic     q_full;
    logic     q_head_valid;
    t_run_cmd q_head;
    logic     q_pop;

    lrle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    lrle_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_push_data),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .i_pop        (q_pop)
    );

    lrle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the level run-length encoder. Random and directed
// level streams are driven across many bit widths. Each encoded byte is
// compared with an in-bench encoder model: varint run header, value bytes
// and the end-of-stream marker. Both sides stall at random, and one long
// output hold backs up the input. A long run of equal levels checks a
// two-byte run header.
// ----------------------------------------------------------------------------
module tb_top;
    import lrle_pkg::*;

    localparam int unsigned MAX_RUN_TB     = MAX_RUN_DEF;
    localparam int unsigned VARINT_CONT    = 'h80;
    localparam int unsigned VARINT_MASK    = 'h7F;
    localparam int unsigned VARINT_SHIFT   = 7;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned QUIET_CYCLES   = 16;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PRESSURE_ITEMS = 40;
    localparam int unsigned RANDOM_TARGET  = 200;
    localparam int unsigned LONG_RUN       = 70;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned TIMEOUT_NS     = 10_000_000;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_enc_byte;

    class rle_scoreboard;
        logic [WIDTH_CFG_W-1:0] width_reg;
        logic [LEVEL_W-1:0]     run_val;
        int unsigned            run_len;
        bit                     run_open;
        t_enc_byte              byte_q[$];
        int unsigned            mismatches;
        int unsigned            bytes_seen;
        int unsigned            runs_closed;
        int unsigned            streams_closed;

        function new();
            width_reg      = WIDTH_RESET;
            run_val        = '0;
            run_len        = 0;
            run_open       = 1'b0;
            mismatches     = 0;
            bytes_seen     = 0;
            runs_closed    = 0;
            streams_closed = 0;
        endfunction

        function void set_width(logic [WIDTH_CFG_W-1:0] w);
            width_reg = w;
        endfunction

        function int unsigned pending();
            return byte_q.size();
        endfunction

        function void push_run(logic [LEVEL_W-1:0] v, int unsigned len);
            int unsigned w;
            int unsigned hdr;
            w = (width_reg > LEVEL_W) ? LEVEL_W : width_reg;
            if (w == 0) return;
            runs_closed++;
            hdr = (len & 'hFFFF) << 1;
            while (hdr >= VARINT_CONT) begin
                byte_q.insert(byte_q.size(),
                              '{1'b0, 8'((hdr & VARINT_MASK) | VARINT_CONT)});
                hdr = hdr >> VARINT_SHIFT;
            end
            byte_q.insert(byte_q.size(), '{1'b0, 8'(hdr)});
            for (int b = 0; b < (w + 7) / 8; b++) begin
                byte_q.insert(byte_q.size(), '{1'b0, v[8*b +: 8]});
            end
        endfunction

        function void note_level(logic [LEVEL_W-1:0] lv, bit eos);
            int unsigned base;
            base = byte_q.size();
            if (run_open && lv == run_val && run_len < MAX_RUN_TB) begin
                run_len++;
            end else begin
                if (run_open) push_run(run_val, run_len);
                run_val  = lv;
                run_len  = 1;
                run_open = 1'b1;
            end
            if (eos) begin
                push_run(run_val, run_len);
                run_open = 1'b0;
                run_val  = '0;
                run_len  = 0;
                streams_closed++;
                if (byte_q.size() > base) byte_q[byte_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void flag(string what, string want_s, int unsigned got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s: expected %s, got 0x%0h", $time, what, want_s, got);
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_enc_byte want;
            bytes_seen++;
            if (byte_q.size() == 0) begin
                flag("out_byte with nothing queued", "none", data);
                return;
            end
            want = byte_q.pop_front();
            if (want.data !== data)
                flag("out_byte", $sformatf("0x%0h", want.data), data);
            if (want.last !== last)
                flag("final_byte", $sformatf("%0d", want.last), last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lrle_cfg_if cfg_if ();
    lrle_in_if  in_if ();
    lrle_out_if out_if ();

    level_run_length_encoder_top #(
        .MAX_RUN (MAX_RUN_TB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rle_scoreboard sb;
    bit            send_idle;
    bit            recv_idle;
    int unsigned   hold_ask;
    int unsigned   items_sent;
    int unsigned   widths_written;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("level_run_length_encoder_top regression: fail");
        $finish;
    end

    // output ready: random stalls plus the long hold on request
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned hold_seen;
        stall_left    = 0;
        hold_left     = 0;
        hold_seen     = 0;
        out_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                stall_left   = $urandom_range(1, 15) - 1;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_byte(out_if.out_byte, out_if.final_byte);
    end

    task automatic send_level(input logic [LEVEL_W-1:0] lv, input bit eos);
        int unsigned gap;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.level         = lv;
        in_if.end_of_stream = eos;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_level(lv, eos);
        items_sent++;
        @(negedge i_clk);
    endtask

    // drop the request and let the encoder drain before a width write
    task automatic wait_quiet();
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [WIDTH_CFG_W-1:0] w);
        wait_quiet();
        cfg_if.valid           = 1'b1;
        cfg_if.level_bit_width = w;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_width(w);
        widths_written++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [WIDTH_CFG_W-1:0] pick_width();
        if ($urandom_range(0, 1) == 0) return WIDTH_CFG_W'($urandom_range(0, 31));
        case ($urandom_range(0, 8))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd7;
            3:       return 5'd8;
            4:       return 5'd9;
            5:       return 5'd15;
            6:       return 5'd16;
            7:       return 5'd17;
            default: return 5'd31;
        endcase
    endfunction

    task automatic send_stream(input bit allow_idle);
        int unsigned       runs;
        int unsigned       len;
        int unsigned       pick;
        logic [LEVEL_W-1:0] lv;
        logic [LEVEL_W-1:0] prev;
        bit                close;
        runs      = $urandom_range(1, 6);
        close     = ($urandom_range(0, 3) != 0);
        prev      = '0;
        send_idle = allow_idle && ($urandom_range(0, 4) != 0);
        recv_idle = allow_idle && ($urandom_range(0, 4) != 0);
        for (int r = 0; r < runs; r++) begin
            case ($urandom_range(0, 3))
                0:       lv = LEVEL_W'($urandom);
                1:       lv = LEVEL_W'($urandom_range(0, 3));
                2:       lv = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                default: lv = prev;
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 15)      len = $urandom_range(1, 3);
            else if (pick < 19) len = $urandom_range(4, 12);
            else                len = $urandom_range(60, 130);
            for (int i = 0; i < len; i++)
                send_level(lv, close && r == runs - 1 && i == len - 1);
            prev = lv;
        end
    endtask

    initial begin
        sb                     = new();
        send_idle              = 1'b0;
        recv_idle              = 1'b0;
        hold_ask               = 0;
        items_sent             = 0;
        widths_written         = 0;
        in_if.valid            = 1'b0;
        in_if.level            = '0;
        in_if.end_of_stream    = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.level_bit_width = '0;
        i_rst_n                = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset width, then corner widths
        send_level(16'h0005, 1'b1);
        send_level(16'h0007, 1'b0);
        send_level(16'h0007, 1'b0);
        send_level(16'h0007, 1'b0);
        send_level(16'h0003, 1'b1);
        write_width(5'd16);
        send_level(16'hFFFF, 1'b0);
        send_level(16'hFFFF, 1'b0);
        send_level(16'h0000, 1'b0);
        send_level(16'h1234, 1'b0);
        send_level(16'h1234, 1'b1);
        write_width(5'd9);
        send_level(16'h01FF, 1'b0);
        send_level(16'h8000, 1'b1);
        write_width(5'd31);
        send_level(16'h00FF, 1'b0);
        send_level(16'hFF00, 1'b1);
        write_width(5'd0);
        send_level(16'h0003, 1'b0);
        send_level(16'h0003, 1'b0);
        send_level(16'h0004, 1'b1);
        send_level(16'h0004, 1'b0);
        // width changes while a run is open
        write_width(5'd8);
        send_level(16'h0004, 1'b0);
        send_level(16'h003C, 1'b0);
        write_width(5'd16);
        send_level(16'h003C, 1'b0);
        send_level(16'h0077, 1'b1);
        send_level(16'h0009, 1'b0);
        send_level(16'h0009, 1'b1);

        while (items_sent < RANDOM_TARGET) begin
            write_width(pick_width());
            repeat ($urandom_range(1, 2)) send_stream(1'b1);
        end

        // long output hold while the input keeps offering
        write_width(5'd16);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_ask++;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_level((i % 2 != 0) ? 16'hFFFF : LEVEL_W'(i), i == PRESSURE_ITEMS - 1);

        // no idling from here on; a long run of equal levels
        write_width(5'd16);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (LONG_RUN) send_level(16'hBEEF, 1'b0);
        send_level(16'h0102, 1'b1);
        write_width(5'd8);
        repeat (3) send_stream(1'b0);
        send_level(16'h00A5, 1'b1);

        wait_quiet();
        $display("Sent %0d level requests over %0d streams with %0d width writes.",
                 items_sent, sb.streams_closed, widths_written);
        $display("Checked %0d encoded bytes from %0d runs; %0d mismatches.",
                 sb.bytes_seen, sb.runs_closed, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("level_run_length_encoder_top regression: pass");
        end else begin
            if (sb.pending() != 0) $display("%0d expected bytes never arrived", sb.pending());
            $display("level_run_length_encoder_top regression: fail");
        end
        $finish;
    end

endmodule
